>>> hdl/rsq_pkg.sv
// Package for the ready slot queue: command codes and the decoded operation struct.
// Used by rsq_cell and ready_slot_queue_core; depends on nothing.

package rsq_pkg;

	localparam int CMD_W = 3;
	localparam int SLOT_IDX_W = 4;

	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR_SLOT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 3'd5;

	typedef struct packed {
		logic push_back;
		logic push_front;
		logic remove;
		logic read;
		logic clear_slot;
		logic clear_all;
	} op_t;

endpackage

>>> hdl/rsq_cell.sv
// One slot of the ready slot queue: record and valid mark, shifting to either neighbor.
// Depends on rsq_pkg for op_t and the slot index width.

module rsq_cell #(
	parameter int INDEX = 0,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  rsq_pkg::op_t                   op,
	input  logic [rsq_pkg::SLOT_IDX_W-1:0] slot_index,
	input  logic [PAYLOAD_WIDTH-1:0]       rec,
	input  logic [PAYLOAD_WIDTH-1:0]       left_payload,
	input  logic                           left_valid,
	input  logic [PAYLOAD_WIDTH-1:0]       right_payload,
	input  logic                           right_valid,
	input  logic                           full_below,
	output logic                           full_out,
	output logic [PAYLOAD_WIDTH-1:0]       payload,
	output logic                           valid,
	output logic                           valid_next,
	output logic [PAYLOAD_WIDTH-1:0]       rd_payload,
	output logic                           rd_valid
);

	logic [PAYLOAD_WIDTH-1:0] payload_q;
	logic                     valid_q;
	logic [PAYLOAD_WIDTH-1:0] payload_d;
	logic                     valid_d;
	logic                     sel;
	logic                     at_or_after;

	assign sel         = int'(slot_index) == INDEX;
	assign at_or_after = int'(slot_index) <= INDEX;

	always_comb begin
		payload_d = payload_q;
		valid_d   = valid_q;
		if (op.push_back && full_below && !valid_q) begin
			payload_d = rec;
			valid_d   = 1'b1;
		end
		if (op.push_front) begin
			payload_d = left_payload;
			valid_d   = left_valid;
		end
		if (op.remove && at_or_after) begin
			payload_d = right_payload;
			valid_d   = right_valid;
		end
		if ((op.clear_slot && sel) || op.clear_all) begin
			valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			payload_q <= payload_d;
		end
	end

	assign full_out   = full_below & valid_q;
	assign payload    = payload_q;
	assign valid      = valid_q;
	assign valid_next = valid_d;
	assign rd_valid   = sel & valid_q;
	assign rd_payload = (sel && valid_q) ? payload_q : '0;

endmodule

>>> hdl/ready_slot_queue_core.sv
// Top level of the ready slot queue: command decode, row of slot cells, result register.
// Depends on rsq_pkg and rsq_cell.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------------
//  in      | in_valid  | in_stall  | cmd, slot_index, entry_in
//  out     | out_valid | out_stall | entry_out, entry_present, queue_empty, overflow
//
// One transaction per cycle while in_stall is low: every command completes in the cycle it is accepted.
// The first-free search ripples through the cell row, QUEUE_DEPTH cells long.
// Reset empties every slot at once; no clearing pass is needed.
// in_stall rises only while a finished result sits in the output register and is stalled.

module ready_slot_queue_core #(
	parameter int QUEUE_DEPTH = 10,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rsq_pkg::CMD_W-1:0]      cmd,
	input  logic [rsq_pkg::SLOT_IDX_W-1:0] slot_index,
	input  logic [PAYLOAD_WIDTH-1:0]       entry_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [PAYLOAD_WIDTH-1:0]       entry_out,
	output logic                           entry_present,
	output logic                           queue_empty,
	output logic                           overflow
);

	rsq_pkg::op_t             op;
	logic                     accept;
	logic                     out_valid_q;
	logic [PAYLOAD_WIDTH-1:0] entry_out_q;
	logic                     entry_present_q;
	logic                     queue_empty_q;
	logic                     overflow_q;

	logic [PAYLOAD_WIDTH-1:0] slot_payload [QUEUE_DEPTH];
	logic [PAYLOAD_WIDTH-1:0] rd_payload   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   slot_valid;
	logic [QUEUE_DEPTH-1:0]   valid_next;
	logic [QUEUE_DEPTH-1:0]   rd_valid;
	logic [QUEUE_DEPTH:0]     full_chain;

	logic [PAYLOAD_WIDTH-1:0] sel_payload;
	logic                     sel_valid;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		op = '0;
		unique case (cmd)
			rsq_pkg::CMD_PUSH_BACK:  op.push_back  = 1'b1;
			rsq_pkg::CMD_PUSH_FRONT: op.push_front = 1'b1;
			rsq_pkg::CMD_REMOVE:     op.remove     = 1'b1;
			rsq_pkg::CMD_READ:       op.read       = 1'b1;
			rsq_pkg::CMD_CLEAR_SLOT: op.clear_slot = 1'b1;
			rsq_pkg::CMD_CLEAR_ALL:  op.clear_all  = 1'b1;
			default: ;
		endcase
	end

	assign full_chain[0] = 1'b1;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [PAYLOAD_WIDTH-1:0] left_payload;
		logic                     left_valid;
		logic [PAYLOAD_WIDTH-1:0] right_payload;
		logic                     right_valid;

		if (i == 0) begin : g_first
			assign left_payload = entry_in;
			assign left_valid   = 1'b1;
		end else begin : g_mid_left
			assign left_payload = slot_payload[i-1];
			assign left_valid   = slot_valid[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_payload = '0;
			assign right_valid   = 1'b0;
		end else begin : g_mid_right
			assign right_payload = slot_payload[i+1];
			assign right_valid   = slot_valid[i+1];
		end

		rsq_cell #(
			.INDEX        (i),
			.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.en           (accept),
			.op           (op),
			.slot_index   (slot_index),
			.rec          (entry_in),
			.left_payload (left_payload),
			.left_valid   (left_valid),
			.right_payload(right_payload),
			.right_valid  (right_valid),
			.full_below   (full_chain[i]),
			.full_out     (full_chain[i+1]),
			.payload      (slot_payload[i]),
			.valid        (slot_valid[i]),
			.valid_next   (valid_next[i]),
			.rd_payload   (rd_payload[i]),
			.rd_valid     (rd_valid[i])
		);
	end

	always_comb begin
		sel_payload = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel_payload = sel_payload | rd_payload[i];
		end
	end

	assign sel_valid = |rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept | in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_out_q     <= (op.read || op.remove) ? sel_payload : '0;
			entry_present_q <= (op.read | op.remove | op.clear_slot) & sel_valid;
			queue_empty_q   <= ~|valid_next;
			overflow_q      <= (op.push_back & full_chain[QUEUE_DEPTH])
			                 | (op.push_front & slot_valid[QUEUE_DEPTH-1]);
		end
	end

	assign out_valid     = out_valid_q;
	assign entry_out     = entry_out_q;
	assign entry_present = entry_present_q;
	assign queue_empty   = queue_empty_q;
	assign overflow      = overflow_q;

`ifndef SYNTHESIS
	a_clear_all_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op.clear_all |=> slot_valid == '0)
		else $error("clear_all left a valid slot");

	a_push_front_head: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op.push_front |=> slot_valid[0])
		else $error("push_front did not fill slot 0");

	a_push_back_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op.push_back && !full_chain[QUEUE_DEPTH]
		|=> $countones(slot_valid) == $past($countones(slot_valid)) + 1)
		else $error("push_back did not add exactly one record");

	a_overflow_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && overflow_q |-> !entry_present_q && !queue_empty_q)
		else $error("overflow result reports an entry or an empty queue");

	a_empty_matches_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> queue_empty_q == (slot_valid == '0))
		else $error("queue_empty disagrees with the slot row");
`endif

endmodule
